>>> rtl/core/sfw_pkg.sv
package sfw_pkg;

  // widths of the configuration and item fields
  localparam int CENTER_W  = 20;
  localparam int SPACING_W = 16;
  localparam int LODIV_W   = 5;
  localparam int XTAL_W    = 16;
  localparam int CHAN_W    = 16;
  localparam int WORD_W    = 24;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 20;

  // datapath widths
  localparam int WORK_W  = 32;
  localparam int RF_W    = 20;
  localparam int UNIT_W  = 17;
  localparam int LDP_W   = 25;
  localparam int CNT_W   = 4;
  localparam int SLICE_W = 2;
  localparam int DIGIT_W = 4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CENTER  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPACING = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LODIV   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_XTAL    = 2'd3;

  // register values after reset
  localparam logic [CENTER_W-1:0]  CENTER_RST  = 20'd0;
  localparam logic [SPACING_W-1:0] SPACING_RST = 16'd2000;
  localparam logic [LODIV_W-1:0]   LODIV_RST   = 5'd4;
  localparam logic [XTAL_W-1:0]    XTAL_RST    = 16'd40000;

  // arithmetic constants
  localparam logic [WORK_W-1:0]  RF_LIMIT    = 32'd1048575;
  localparam logic [XTAL_W-1:0]  XTAL_MIN    = 16'd1000;
  localparam logic [RF_W-1:0]    SMALL_LIMIT = 20'd1000;
  localparam logic [DIGIT_W-1:0] ROUND_DIGIT = 4'd5;
  // x / 10 for any 32-bit x is (x * RECIP10) >> DIV10_SHIFT
  localparam logic [WORK_W-1:0]  RECIP10     = 32'hCCCC_CCCD;
  localparam int                 DIV10_SHIFT = 35;

  // divider: two quotient bits per cycle over the 32-bit dividend
  localparam int                DIV_BITS_PER_STEP = 2;
  localparam logic [CNT_W-1:0]  DIV_LAST = CNT_W'(WORK_W / DIV_BITS_PER_STEP - 1);

  typedef struct packed {
    logic load;
    logic step;
  } div_ctl_t;

  // microcode
  typedef enum logic [4:0] {
    OP_NONE,
    OP_MUL_CS,
    OP_DIV10,
    OP_ADD_CENTER,
    OP_INIT,
    OP_SLICE_INIT,
    OP_SUB_UNIT,
    OP_PREP,
    OP_DIV_START,
    OP_DIV_STEP,
    OP_DIV_END,
    OP_DIV10_DEC,
    OP_ROUND,
    OP_ACCUM,
    OP_NEXT,
    OP_EMIT_OK,
    OP_EMIT_ERR
  } op_t;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_RANGE,
    C_RF_ZERO,
    C_RF_GE_UNIT,
    C_HZ_ZERO,
    C_CNT_NZ,
    C_CNT_ZERO,
    C_K_ZERO,
    C_OUT_BLOCK
  } cond_t;

  localparam int STEP_W   = 5;
  localparam int PROG_LEN = 18;
  typedef logic [STEP_W-1:0] step_t;

  localparam step_t S_MUL      = 5'd0;
  localparam step_t S_DIV_CS   = 5'd1;
  localparam step_t S_ADD      = 5'd2;
  localparam step_t S_INIT     = 5'd3;
  localparam step_t S_SLICE    = 5'd4;
  localparam step_t S_SUB      = 5'd5;
  localparam step_t S_PREP     = 5'd6;
  localparam step_t S_DSTART   = 5'd7;
  localparam step_t S_DSTEP    = 5'd8;
  localparam step_t S_DEND     = 5'd9;
  localparam step_t S_PRE_CHK  = 5'd10;
  localparam step_t S_PRE_DIV  = 5'd11;
  localparam step_t S_LAST_DIV = 5'd12;
  localparam step_t S_ROUND    = 5'd13;
  localparam step_t S_ACCUM    = 5'd14;
  localparam step_t S_NEXT     = 5'd15;
  localparam step_t S_FIN      = 5'd16;
  localparam step_t S_ERR      = 5'd17;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
    logic  last;
  } ctrl_t;

  // control store: jump to target when cond holds, else fall through
  function automatic ctrl_t program_word(input step_t s);
    ctrl_t w;
    case (s)
      S_MUL:      w = '{op: OP_MUL_CS,     cond: C_NEVER,     target: S_MUL,      last: 1'b0};
      S_DIV_CS:   w = '{op: OP_DIV10,      cond: C_NEVER,     target: S_MUL,      last: 1'b0};
      S_ADD:      w = '{op: OP_ADD_CENTER, cond: C_NEVER,     target: S_MUL,      last: 1'b0};
      S_INIT:     w = '{op: OP_INIT,       cond: C_RANGE,     target: S_ERR,      last: 1'b0};
      S_SLICE:    w = '{op: OP_SLICE_INIT, cond: C_RF_ZERO,   target: S_FIN,      last: 1'b0};
      S_SUB:      w = '{op: OP_SUB_UNIT,   cond: C_RF_GE_UNIT, target: S_SUB,     last: 1'b0};
      S_PREP:     w = '{op: OP_PREP,       cond: C_HZ_ZERO,   target: S_NEXT,     last: 1'b0};
      S_DSTART:   w = '{op: OP_DIV_START,  cond: C_NEVER,     target: S_MUL,      last: 1'b0};
      S_DSTEP:    w = '{op: OP_DIV_STEP,   cond: C_CNT_NZ,    target: S_DSTEP,    last: 1'b0};
      S_DEND:     w = '{op: OP_DIV_END,    cond: C_K_ZERO,    target: S_ACCUM,    last: 1'b0};
      S_PRE_CHK:  w = '{op: OP_NONE,       cond: C_CNT_ZERO,  target: S_LAST_DIV, last: 1'b0};
      S_PRE_DIV:  w = '{op: OP_DIV10_DEC,  cond: C_ALWAYS,    target: S_PRE_CHK,  last: 1'b0};
      S_LAST_DIV: w = '{op: OP_DIV10,      cond: C_NEVER,     target: S_MUL,      last: 1'b0};
      S_ROUND:    w = '{op: OP_ROUND,      cond: C_NEVER,     target: S_MUL,      last: 1'b0};
      S_ACCUM:    w = '{op: OP_ACCUM,      cond: C_NEVER,     target: S_MUL,      last: 1'b0};
      S_NEXT:     w = '{op: OP_NEXT,       cond: C_ALWAYS,    target: S_SLICE,    last: 1'b0};
      S_FIN:      w = '{op: OP_EMIT_OK,    cond: C_OUT_BLOCK, target: S_FIN,      last: 1'b1};
      S_ERR:      w = '{op: OP_EMIT_ERR,   cond: C_OUT_BLOCK, target: S_ERR,      last: 1'b1};
      default:    w = '{op: OP_NONE,       cond: C_NEVER,     target: S_MUL,      last: 1'b1};
    endcase
    return w;
  endfunction

  // decimal slice size for slice index k
  function automatic logic [UNIT_W-1:0] slice_unit(input logic [SLICE_W-1:0] k);
    logic [UNIT_W-1:0] u;
    case (k)
      2'd0:    u = 17'd100000;
      2'd1:    u = 17'd10000;
      2'd2:    u = 17'd1000;
      default: u = 17'd100;
    endcase
    return u;
  endfunction

endpackage

>>> rtl/core/sfw_divider.sv
module sfw_divider (
  input  logic                           clk,
  input  sfw_pkg::div_ctl_t              ctl,
  input  logic [sfw_pkg::WORK_W-1:0]     dividend,
  input  logic [sfw_pkg::XTAL_W-1:0]     divisor,
  output logic [sfw_pkg::WORK_W-1:0]     quotient
);

  logic [sfw_pkg::XTAL_W-1:0] rem;
  logic [sfw_pkg::WORK_W-1:0] q;

  logic [sfw_pkg::XTAL_W:0]   r1, r2, d1, d2;
  logic                       ge1, ge2;
  logic [sfw_pkg::XTAL_W-1:0] rem1, rem2;
  logic [sfw_pkg::WORK_W-1:0] q1, q2;

  // two restoring steps per cycle, quotient bits shift in from the right
  always_comb begin
    r1   = {rem, q[sfw_pkg::WORK_W-1]};
    d1   = r1 - {1'b0, divisor};
    ge1  = (r1 >= {1'b0, divisor});
    rem1 = ge1 ? d1[sfw_pkg::XTAL_W-1:0] : r1[sfw_pkg::XTAL_W-1:0];
    q1   = {q[sfw_pkg::WORK_W-2:0], ge1};
    r2   = {rem1, q1[sfw_pkg::WORK_W-1]};
    d2   = r2 - {1'b0, divisor};
    ge2  = (r2 >= {1'b0, divisor});
    rem2 = ge2 ? d2[sfw_pkg::XTAL_W-1:0] : r2[sfw_pkg::XTAL_W-1:0];
    q2   = {q1[sfw_pkg::WORK_W-2:0], ge2};
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      rem <= '0;
      q   <= dividend;
    end else if (ctl.step) begin
      rem <= rem2;
      q   <= q2;
    end
  end

  assign quotient = q;

endmodule

>>> rtl/core/synth_freq_word_from_channel.sv
// Turns a channel number into the 24-bit synthesizer frequency word. One item is
// worked on at a time by a small microcoded sequencer: the target RF is formed as
// center + channel * spacing / 10, checked against 1048575 kHz, then split into
// decimal slices of 100000, 10000 and 1000 kHz plus a remainder, and each slice
// is scaled by lo_divider * 65536 / xtal through a shared divider that yields two
// quotient bits per cycle. An item out of range goes straight to an error word and a
// zero target straight to the result; the work on each nonzero slice is set mostly
// by the divide, by the subtract loop that peels off its decimal digit and by the
// divides by ten of the later slices. The result sits in an output register, so the
// next item can be taken while it waits. Configuration writes take effect at once
// and are meant to happen only while the block is idle.
module synth_freq_word_from_channel (
  input  logic                              clk,
  input  logic                              rst,
  // configuration
  input  logic                              cfg_write,
  input  logic [sfw_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sfw_pkg::CFG_DATA_W-1:0]    cfg_data,
  // channel items
  input  logic                              chan_valid,
  output logic                              chan_stall,
  input  logic [sfw_pkg::CHAN_W-1:0]        channel,
  // frequency word items
  output logic                              word_valid,
  input  logic                              word_stall,
  output logic [sfw_pkg::WORD_W-1:0]        freq_word,
  output logic                              range_error
);

  // configuration registers
  logic [sfw_pkg::CENTER_W-1:0]  center_freq_khz;
  logic [sfw_pkg::SPACING_W-1:0] spacing_100hz;
  logic [sfw_pkg::LODIV_W-1:0]   lo_divider;
  logic [sfw_pkg::XTAL_W-1:0]    xtal_khz;

  // sequencer
  logic                  busy;
  sfw_pkg::step_t        pc;
  sfw_pkg::ctrl_t        cw;
  logic                  take;
  logic                  out_block;
  logic                  emit_fire;

  // datapath registers
  logic [sfw_pkg::CHAN_W-1:0]  chan_q;
  logic [sfw_pkg::WORK_W-1:0]  work;
  logic [sfw_pkg::WORK_W-1:0]  prev;
  logic [sfw_pkg::RF_W-1:0]    rf;
  logic [sfw_pkg::RF_W-1:0]    hz;
  logic [sfw_pkg::WORD_W-1:0]  sum;
  logic [sfw_pkg::XTAL_W-1:0]  xt;
  logic [sfw_pkg::SLICE_W-1:0] k;
  logic [sfw_pkg::CNT_W-1:0]   cnt;
  logic                        small_slice;

  // datapath logic
  logic [sfw_pkg::WORK_W-1:0]   cs_prod;
  logic [sfw_pkg::LDP_W-1:0]    ld_prod;
  logic                         small_c;
  logic [sfw_pkg::WORK_W-1:0]   mul10_in;
  logic [2*sfw_pkg::WORK_W-1:0] mul10_prod;
  logic [sfw_pkg::WORK_W-1:0]   q10;
  logic [sfw_pkg::UNIT_W-1:0]   unit;
  logic [sfw_pkg::RF_W-1:0]     unit_ext;
  logic                         rf_ge_unit;
  logic [sfw_pkg::WORK_W-1:0]   ten_x;
  logic [sfw_pkg::WORK_W-1:0]   digit_wide;
  logic                         round_up;
  logic [sfw_pkg::XTAL_W-1:0]   xt_init;
  logic [sfw_pkg::WORK_W-1:0]   quo;
  sfw_pkg::div_ctl_t            div_ctl;

  assign cw = sfw_pkg::program_word(pc);

  // arithmetic around the work register
  assign cs_prod    = sfw_pkg::WORK_W'(chan_q) * sfw_pkg::WORK_W'(spacing_100hz);
  assign ld_prod    = sfw_pkg::LDP_W'(hz) * sfw_pkg::LDP_W'(lo_divider);
  assign small_c    = (hz < sfw_pkg::SMALL_LIMIT);
  assign mul10_in   = (cw.op == sfw_pkg::OP_NEXT) ? {{(sfw_pkg::WORK_W-sfw_pkg::XTAL_W){1'b0}}, xt}
                                                  : work;
  assign mul10_prod = {{sfw_pkg::WORK_W{1'b0}}, mul10_in} *
                      {{sfw_pkg::WORK_W{1'b0}}, sfw_pkg::RECIP10};
  assign q10        = sfw_pkg::WORK_W'(mul10_prod[2*sfw_pkg::WORK_W-1:sfw_pkg::DIV10_SHIFT]);
  assign unit       = sfw_pkg::slice_unit(k);
  assign unit_ext   = sfw_pkg::RF_W'(unit);
  assign rf_ge_unit = (rf >= unit_ext);
  assign ten_x      = {work[sfw_pkg::WORK_W-4:0], 3'b000} + {work[sfw_pkg::WORK_W-2:0], 1'b0};
  assign digit_wide = prev - ten_x;
  assign round_up   = (digit_wide[sfw_pkg::DIGIT_W-1:0] > sfw_pkg::ROUND_DIGIT);
  assign xt_init    = (xtal_khz < sfw_pkg::XTAL_MIN) ? sfw_pkg::XTAL_MIN : xtal_khz;

  // jump conditions
  always_comb begin
    case (cw.cond)
      sfw_pkg::C_NEVER:      take = 1'b0;
      sfw_pkg::C_ALWAYS:     take = 1'b1;
      sfw_pkg::C_RANGE:      take = (work > sfw_pkg::RF_LIMIT);
      sfw_pkg::C_RF_ZERO:    take = (rf == '0);
      sfw_pkg::C_RF_GE_UNIT: take = rf_ge_unit;
      sfw_pkg::C_HZ_ZERO:    take = (hz == '0);
      sfw_pkg::C_CNT_NZ:     take = (cnt != '0);
      sfw_pkg::C_CNT_ZERO:   take = (cnt == '0);
      sfw_pkg::C_K_ZERO:     take = (k == '0);
      sfw_pkg::C_OUT_BLOCK:  take = out_block;
      default:               take = 1'b0;
    endcase
  end

  assign out_block = word_valid & word_stall;
  assign emit_fire = busy & ~out_block &
                     ((cw.op == sfw_pkg::OP_EMIT_OK) | (cw.op == sfw_pkg::OP_EMIT_ERR));
  assign chan_stall = busy;

  // shared divider, dividend from the work register, divisor the scaled crystal
  assign div_ctl.load = busy & (cw.op == sfw_pkg::OP_DIV_START);
  assign div_ctl.step = busy & (cw.op == sfw_pkg::OP_DIV_STEP);

  sfw_divider u_div (
    .clk      (clk),
    .ctl      (div_ctl),
    .dividend (work),
    .divisor  (xt),
    .quotient (quo)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      center_freq_khz <= sfw_pkg::CENTER_RST;
      spacing_100hz   <= sfw_pkg::SPACING_RST;
      lo_divider      <= sfw_pkg::LODIV_RST;
      xtal_khz        <= sfw_pkg::XTAL_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        sfw_pkg::REG_CENTER:  center_freq_khz <= cfg_data;
        sfw_pkg::REG_SPACING: spacing_100hz   <= cfg_data[sfw_pkg::SPACING_W-1:0];
        sfw_pkg::REG_LODIV:   lo_divider      <= cfg_data[sfw_pkg::LODIV_W-1:0];
        sfw_pkg::REG_XTAL:    xtal_khz        <= cfg_data[sfw_pkg::XTAL_W-1:0];
        default: ;
      endcase
    end
  end

  // step counter and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      pc         <= sfw_pkg::S_MUL;
      word_valid <= 1'b0;
    end else begin
      if (word_valid && !word_stall) begin
        word_valid <= 1'b0;
      end
      if (emit_fire) begin
        word_valid <= 1'b1;
      end
      if (!busy) begin
        if (chan_valid) begin
          busy <= 1'b1;
          pc   <= sfw_pkg::S_MUL;
        end
      end else if (take) begin
        pc <= cw.target;
      end else if (cw.last) begin
        busy <= 1'b0;
      end else begin
        pc <= pc + 1'b1;
      end
    end
  end

  // datapath, driven by the current control word
  always_ff @(posedge clk) begin
    if (!busy && chan_valid) begin
      chan_q <= channel;
    end
    if (emit_fire) begin
      freq_word   <= (cw.op == sfw_pkg::OP_EMIT_OK) ? sum : '0;
      range_error <= (cw.op == sfw_pkg::OP_EMIT_ERR);
    end
    if (busy) begin
      case (cw.op)
        sfw_pkg::OP_MUL_CS: begin
          work <= cs_prod;
        end
        sfw_pkg::OP_DIV10: begin
          prev <= work;
          work <= q10;
        end
        sfw_pkg::OP_ADD_CENTER: begin
          work <= work + sfw_pkg::WORK_W'(center_freq_khz);
        end
        sfw_pkg::OP_INIT: begin
          rf  <= work[sfw_pkg::RF_W-1:0];
          sum <= '0;
          k   <= '0;
          xt  <= xt_init;
        end
        sfw_pkg::OP_SLICE_INIT: begin
          // a remainder below 1000 kHz is taken whole
          if (rf < sfw_pkg::SMALL_LIMIT) begin
            hz <= rf;
            rf <= '0;
          end else begin
            hz <= '0;
          end
        end
        sfw_pkg::OP_SUB_UNIT: begin
          if (rf_ge_unit) begin
            rf <= rf - unit_ext;
            hz <= hz + unit_ext;
          end
        end
        sfw_pkg::OP_PREP: begin
          small_slice <= small_c;
          work  <= small_c ? {ld_prod[sfw_pkg::XTAL_W-1:0], {sfw_pkg::XTAL_W{1'b0}}}
                           : sfw_pkg::WORK_W'(ld_prod);
        end
        sfw_pkg::OP_DIV_START: begin
          cnt <= sfw_pkg::DIV_LAST;
        end
        sfw_pkg::OP_DIV_STEP: begin
          cnt <= cnt - 1'b1;
        end
        sfw_pkg::OP_DIV_END: begin
          // large slices are scaled by 65536 after the divide
          work <= small_slice ? quo : {quo[sfw_pkg::XTAL_W-1:0], {sfw_pkg::XTAL_W{1'b0}}};
          cnt  <= sfw_pkg::CNT_W'(k) - 1'b1;
        end
        sfw_pkg::OP_DIV10_DEC: begin
          work <= q10;
          cnt  <= cnt - 1'b1;
        end
        sfw_pkg::OP_ROUND: begin
          work <= work + sfw_pkg::WORK_W'(round_up);
        end
        sfw_pkg::OP_ACCUM: begin
          sum <= sum + work[sfw_pkg::WORD_W-1:0];
        end
        sfw_pkg::OP_NEXT: begin
          k  <= k + 1'b1;
          xt <= q10[sfw_pkg::XTAL_W-1:0];
        end
        default: ;
      endcase
    end
  end

  // checks
  a_err_word_zero: assert property (@(posedge clk) disable iff (rst)
    word_valid && range_error |-> freq_word == '0)
    else $error("range error item carries a nonzero word");

  a_emit_from_program: assert property (@(posedge clk) disable iff (rst)
    $rose(word_valid) |-> $past(busy))
    else $error("item produced without an active program");

  a_div_full_length: assert property (@(posedge clk) disable iff (rst)
    busy && cw.op == sfw_pkg::OP_DIV_END |-> $past(cw.op) == sfw_pkg::OP_DIV_STEP &&
                                              $past(cnt) == '0)
    else $error("divide ended before all quotient bits were formed");

  a_pc_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> pc < sfw_pkg::STEP_W'(sfw_pkg::PROG_LEN))
    else $error("step counter outside the program");

endmodule

>>> tb/sv/tb_synth_freq_word_from_channel.sv
module tb_synth_freq_word_from_channel;
  timeunit 1ns;
  timeprecision 1ps;

  // arithmetic of the frequency word
  localparam longint unsigned KHZ_PER_WHOLE = 1000;
  localparam longint unsigned TOP_UNIT      = 100000;
  localparam longint unsigned WORD_SCALE    = 65536;
  localparam longint unsigned ROUND_ABOVE   = 5;
  localparam int              MAX_SLICES    = 4;
  localparam int              IDLE_PCT      = 14;

  typedef struct packed {
    logic [sfw_pkg::WORD_W-1:0] word;
    logic                       range_err;
  } freq_result_t;

  // register copy, expected words and mismatch count
  class freq_word_board;
    logic [sfw_pkg::CENTER_W-1:0]  center;
    logic [sfw_pkg::SPACING_W-1:0] spacing;
    logic [sfw_pkg::LODIV_W-1:0]   lodiv;
    logic [sfw_pkg::XTAL_W-1:0]    xtal;
    freq_result_t                  expected_words[$];
    int                            errors;

    function new();
      center  = sfw_pkg::CENTER_RST;
      spacing = sfw_pkg::SPACING_RST;
      lodiv   = sfw_pkg::LODIV_RST;
      xtal    = sfw_pkg::XTAL_RST;
      errors  = 0;
    endfunction

    function void set_reg(logic [sfw_pkg::CFG_IDX_W-1:0] idx,
                          logic [sfw_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        sfw_pkg::REG_CENTER:  center  = data[sfw_pkg::CENTER_W-1:0];
        sfw_pkg::REG_SPACING: spacing = data[sfw_pkg::SPACING_W-1:0];
        sfw_pkg::REG_LODIV:   lodiv   = data[sfw_pkg::LODIV_W-1:0];
        sfw_pkg::REG_XTAL:    xtal    = data[sfw_pkg::XTAL_W-1:0];
        default: ;
      endcase
    endfunction

    // target rf, then the decimal slices scaled by lodiv * 65536 / xtal
    function freq_result_t predict_word(logic [sfw_pkg::CHAN_W-1:0] ch);
      freq_result_t r;
      logic [63:0] rf, xt, unit, scale, total, hz, part, dropped;
      int k;
      rf = 64'(center) + (64'(ch) * 64'(spacing)) / 64'd10;
      xt = (xtal < sfw_pkg::XTAL_MIN) ? 64'(sfw_pkg::XTAL_MIN) : 64'(xtal);
      r.word = '0;
      r.range_err = 1'b0;
      if (rf > 64'(sfw_pkg::RF_LIMIT)) begin
        r.range_err = 1'b1;
        return r;
      end
      unit  = TOP_UNIT;
      scale = 1;
      total = 0;
      for (k = 0; k < MAX_SLICES && rf != 0; k++) begin
        hz = (rf < KHZ_PER_WHOLE) ? rf : (rf / unit) * unit;
        if (hz < KHZ_PER_WHOLE) begin
          part = (hz * 64'(lodiv) * WORD_SCALE) / xt;
        end else begin
          part = ((hz * 64'(lodiv)) / xt) * WORD_SCALE;
        end
        dropped = part % scale;
        part = part / scale;
        // round up when the first dropped digit is 6 or more
        if (scale > 1 && dropped / (scale / 10) > ROUND_ABOVE) begin
          part = part + 1;
        end
        total = total + part;
        scale = scale * 10;
        unit  = unit / 10;
        xt    = xt / 10;
        rf    = rf - hz;
      end
      r.word = total[sfw_pkg::WORD_W-1:0];
      return r;
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      errors++;
    endtask

    function void note_channel(logic [sfw_pkg::CHAN_W-1:0] ch);
      expected_words.push_back(predict_word(ch));
    endfunction

    task check_word(logic [sfw_pkg::WORD_W-1:0] word, logic range_err);
      freq_result_t want;
      if (expected_words.size() == 0) begin
        report($sformatf("freq word 0x%06h with no item waiting", word));
        return;
      end
      want = expected_words.pop_front();
      if (word !== want.word) begin
        report($sformatf("freq_word 0x%06h, expected 0x%06h", word, want.word));
      end
      if (range_err !== want.range_err) begin
        report($sformatf("range_error %b, expected %b", range_err, want.range_err));
      end
    endtask
  endclass

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           cfg_write = 1'b0;
  logic [sfw_pkg::CFG_IDX_W-1:0]  cfg_index = sfw_pkg::REG_CENTER;
  logic [sfw_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic                           chan_valid = 1'b0;
  logic                           chan_stall;
  logic [sfw_pkg::CHAN_W-1:0]     channel = '0;
  logic                           word_valid;
  logic                           word_stall = 1'b0;
  logic [sfw_pkg::WORD_W-1:0]     freq_word;
  logic                           range_error;

  freq_word_board board = new();
  int             chan_taken = 0;
  logic           quiet = 1'b0;

  synth_freq_word_from_channel i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .chan_valid (chan_valid),
    .chan_stall (chan_stall),
    .channel    (channel),
    .word_valid (word_valid),
    .word_stall (word_stall),
    .freq_word  (freq_word),
    .range_error(range_error)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #8_000_000;
    $display("status: fail");
    $finish;
  end

  // item handshakes on both channels
  always @(posedge clk) begin
    if (!rst && chan_valid && !chan_stall) begin
      board.note_channel(channel);
      chan_taken++;
    end
    if (!rst && word_valid && !word_stall) begin
      board.check_word(freq_word, range_error);
    end
  end

  // receiver stalls at random
  always @(negedge clk) begin
    word_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
  end

  task automatic write_reg(input logic [sfw_pkg::CFG_IDX_W-1:0] idx,
                           input logic [sfw_pkg::CFG_DATA_W-1:0] data);
    board.set_reg(idx, data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  task automatic apply_config(input int unsigned center, input int unsigned spacing,
                              input int unsigned lodiv, input int unsigned xtal);
    write_reg(sfw_pkg::REG_CENTER, sfw_pkg::CFG_DATA_W'(center));
    write_reg(sfw_pkg::REG_SPACING, sfw_pkg::CFG_DATA_W'(spacing));
    write_reg(sfw_pkg::REG_LODIV, sfw_pkg::CFG_DATA_W'(lodiv));
    write_reg(sfw_pkg::REG_XTAL, sfw_pkg::CFG_DATA_W'(xtal));
  endtask

  // holds valid until the item is taken; valid stays up for a following item
  task automatic send_channel(input logic [sfw_pkg::CHAN_W-1:0] ch);
    int seen;
    while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
      chan_valid <= 1'b0;
      @(negedge clk);
    end
    chan_valid <= 1'b1;
    channel    <= ch;
    seen = chan_taken;
    do @(negedge clk); while (chan_taken == seen);
  endtask

  task automatic wait_drained();
    chan_valid <= 1'b0;
    @(negedge clk);
    while (board.expected_words.size() != 0) @(negedge clk);
  endtask

  // channels mostly inside the rf limit, some at its edge, some anywhere
  function automatic logic [sfw_pkg::CHAN_W-1:0] pick_channel();
    longint unsigned headroom;
    int unsigned maxch;
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (board.spacing == 0 || pick < 3) begin
      return sfw_pkg::CHAN_W'($urandom);
    end
    headroom = (longint'(sfw_pkg::RF_LIMIT) - longint'(board.center)) * 10 / board.spacing;
    maxch = (headroom > 65535) ? 65535 : int'(headroom);
    if (pick == 3) return sfw_pkg::CHAN_W'(maxch);
    if (pick == 4 && maxch < 65535) return sfw_pkg::CHAN_W'(maxch + 1);
    return sfw_pkg::CHAN_W'($urandom_range(0, maxch));
  endfunction

  function automatic int unsigned pick_xtal();
    if ($urandom_range(0, 9) < 3) return $urandom_range(0, 65535);
    return $urandom_range(1000, 65535);
  endfunction

  initial begin
    int phase;
    int n;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: zero target, small rf, edges of the rf limit
    send_channel(0);
    send_channel(1);
    send_channel(5);
    send_channel(4369);
    send_channel(5242);
    send_channel(5243);
    send_channel(65535);
    wait_drained();

    // top rf, divider 31 and smallest crystal: word wraps
    apply_config(1048575, 0, 31, 1000);
    send_channel(0);
    send_channel(65535);
    wait_drained();

    // one past the rf limit
    apply_config(1048575, 10, 30, 65535);
    send_channel(0);
    send_channel(1);
    wait_drained();

    // crystal of zero, divider of zero, widest spacing
    apply_config(0, 65535, 0, 0);
    send_channel(65535);
    send_channel(16);
    wait_drained();

    // crystal just below the minimum
    apply_config(123456, 7, 1, 999);
    send_channel(0);
    send_channel(65535);
    send_channel(3);
    wait_drained();

    // rf below 1000 taken whole, and right at 1000
    apply_config(999, 1, 17, 12345);
    send_channel(0);
    send_channel(10);
    send_channel(9990);
    wait_drained();

    // random phases, each with its own settings
    for (phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: apply_config($urandom_range(0, 1048575), $urandom_range(0, 65535),
                        $urandom_range(0, 31), pick_xtal());
        1: apply_config($urandom_range(0, 1048575), $urandom_range(0, 200),
                        $urandom_range(0, 31), pick_xtal());
        2: apply_config($urandom_range(0, 3000), $urandom_range(1, 40),
                        $urandom_range(0, 31), pick_xtal());
        default: apply_config($urandom_range(0, 1) ? 1048575 : $urandom_range(0, 1048575),
                              $urandom_range(0, 1) ? 65535 : 0,
                              $urandom_range(0, 1) ? 31 : 0,
                              $urandom_range(0, 1) ? 65535 : $urandom_range(0, 1000));
      endcase
      quiet <= (phase == 4);
      for (n = 0; n < 130; n++) begin
        send_channel(pick_channel());
        // sender holds off until every word is back
        if ($urandom_range(0, 49) == 0) wait_drained();
      end
      wait_drained();
    end
    quiet <= 1'b0;

    repeat (200) @(negedge clk);
    if (board.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
